[sv/ptar_pkg.sv]
// ----------------------------------------------------------------------------
// ptar_pkg: shared constants, types and coefficient tables
// Epochs, century lengths, reciprocals, the arcsec-to-radian factor and the
// per-model cubic coefficients (2^-32 arcsec, rounded to nearest).
// ----------------------------------------------------------------------------
package ptar_pkg;

  // Stream layout
  localparam int DATE_W      = 38;
  localparam int MODEL_W     = 3;
  localparam int ANGLE_W     = 56;
  localparam int RATE_W      = 48;
  localparam int IN_DATA_W   = 80;   // two dates, zero padded to whole bytes
  localparam int OUT_DATA_W  = ANGLE_W + RATE_W;

  // Stages inside ptar_mul: magnitude, partial products, sum/round, sign
  localparam int MUL_LAT = 4;

  typedef enum logic [MODEL_W-1:0] {
    MODEL_NEWCOMB   = 3'd0,
    MODEL_ANDOYER   = 3'd1,
    MODEL_KINOSHITA = 3'd2,
    MODEL_LIESKE    = 3'd3,
    MODEL_FK5       = 3'd4
  } model_t;

  // Epochs and century lengths in 2^-16 day
  localparam logic [DATE_W-1:0] EPOCH_B1850 = 38'(64'd2396758 * 64'd65536 + 64'd13342);
  localparam logic [DATE_W-1:0] EPOCH_J2000 = 38'(64'd2451545 * 64'd65536);
  localparam logic [31:0] CENT_TROP = 32'(64'd36524 * 64'd65536 + 64'd14410);
  localparam logic [31:0] CENT_JUL  = 32'(64'd36525 * 64'd65536);

  // floor(2^80 / century), below 2^49
  localparam logic [80:0] TWO80   = 81'd1 << 80;
  localparam logic [48:0] RC_TROP = 49'(TWO80 / 81'(CENT_TROP));
  localparam logic [48:0] RC_JUL  = 49'(TWO80 / 81'(CENT_JUL));

  // round(pi * 2^80 / 648000), below 2^63
  localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C235;
  localparam logic [62:0] ARCSEC_K =
    63'(((82'(PI_Q62) << 18) + 82'd324000) / 82'd648000);

  // Coefficient magnitudes, round(n/d * 2^32)
  localparam longint Q33 = 64'sd8589934592;

  localparam longint NW_C10 = (2004682 * Q33 + 1000) / 2000;
  localparam longint NW_C11 = (853 * Q33 + 1000) / 2000;
  localparam longint NW_C20 = (426 * Q33 + 1000) / 2000;
  localparam longint NW_C30 = (42 * Q33 + 1000) / 2000;

  localparam longint AN_C10 = (2005112 * Q33 + 1000) / 2000;
  localparam longint AN_C11 = (8529 * Q33 + 10000) / 20000;
  localparam longint AN_C12 = (37 * Q33 + 100000) / 200000;
  localparam longint AN_C20 = (4265 * Q33 + 10000) / 20000;
  localparam longint AN_C30 = (418 * Q33 + 10000) / 20000;

  localparam longint KI_C10 = (20051125 * Q33 + 10000) / 20000;
  localparam longint KI_C11 = (85294 * Q33 + 100000) / 200000;
  localparam longint KI_C12 = (365 * Q33 + 1000000) / 2000000;
  localparam longint KI_C20 = (42647 * Q33 + 100000) / 200000;
  localparam longint KI_C30 = (41802 * Q33 + 1000000) / 2000000;

  localparam longint LI_C10 = (2004684 * Q33 + 1000) / 2000;
  localparam longint LI_C11 = (8532 * Q33 + 10000) / 20000;
  localparam longint LI_C12 = (317 * Q33 + 1000000) / 2000000;
  localparam longint LI_C20 = (4266 * Q33 + 10000) / 20000;
  localparam longint LI_C21 = (32 * Q33 + 100000) / 200000;
  localparam longint LI_C30 = (418 * Q33 + 10000) / 20000;

  localparam longint FK_C10 = (20043109 * Q33 + 10000) / 20000;
  localparam longint FK_C11 = (85330 * Q33 + 100000) / 200000;
  localparam longint FK_C12 = (217 * Q33 + 1000000) / 2000000;
  localparam longint FK_C20 = (42665 * Q33 + 100000) / 200000;
  localparam longint FK_C30 = (41833 * Q33 + 1000000) / 2000000;

  typedef struct packed {
    logic signed [44:0] c10;
    logic signed [32:0] c11;
    logic signed [21:0] c12;
    logic signed [31:0] c20;
    logic signed [21:0] c21;
    logic signed [28:0] c30;
    logic signed [30:0] c30x3;
    logic               half;    // epoch offset by half a century
    logic               julian;  // J2000 and Julian centuries
  } coef_t;

  function automatic coef_t model_coef(model_t m);
    coef_t c;
    c = '0;
    unique case (m)
      MODEL_NEWCOMB: begin
        c.c10   = 45'(NW_C10);
        c.c11   = -33'(NW_C11);
        c.c12   = '0;
        c.c20   = -32'(NW_C20);
        c.c21   = '0;
        c.c30   = -29'(NW_C30);
        c.c30x3 = -31'(3 * NW_C30);
        c.half  = 1'b1;
      end
      MODEL_ANDOYER: begin
        c.c10   = 45'(AN_C10);
        c.c11   = -33'(AN_C11);
        c.c12   = -22'(AN_C12);
        c.c20   = -32'(AN_C20);
        c.c21   = -22'(AN_C12);
        c.c30   = -29'(AN_C30);
        c.c30x3 = -31'(3 * AN_C30);
      end
      MODEL_KINOSHITA: begin
        c.c10   = 45'(KI_C10);
        c.c11   = -33'(KI_C11);
        c.c12   = -22'(KI_C12);
        c.c20   = -32'(KI_C20);
        c.c21   = -22'(KI_C12);
        c.c30   = -29'(KI_C30);
        c.c30x3 = -31'(3 * KI_C30);
      end
      MODEL_LIESKE: begin
        c.c10   = 45'(LI_C10);
        c.c11   = -33'(LI_C11);
        c.c12   = -22'(LI_C12);
        c.c20   = -32'(LI_C20);
        c.c21   = -22'(LI_C21);
        c.c30   = -29'(LI_C30);
        c.c30x3 = -31'(3 * LI_C30);
        c.half  = 1'b1;
      end
      default: begin
        c.c10    = 45'(FK_C10);
        c.c11    = -33'(FK_C11);
        c.c12    = -22'(FK_C12);
        c.c20    = -32'(FK_C20);
        c.c21    = -22'(FK_C12);
        c.c30    = -29'(FK_C30);
        c.c30x3  = -31'(3 * FK_C30);
        c.julian = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

[sv/ptar_mul.sv]
// ----------------------------------------------------------------------------
// ptar_mul: pipelined signed multiply, shift and round
// p = sign(a*b) * ((|a|*|b| + 2^(SH-1)) >> SH), built from 32x32 partial
// products over four register stages, advancing when en is high.
// ----------------------------------------------------------------------------
module ptar_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SH = 32,
  parameter int OW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [OW-1:0] p
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int AP = NA * 32;
  localparam int BP = NB * 32;
  localparam int PW = AW + BW;
  localparam logic [PW-1:0] RND = PW'(1) << (SH - 1);

  logic [AW-1:0] a_abs;
  logic [BW-1:0] b_abs;
  logic [AP-1:0] am;
  logic [BP-1:0] bm;
  logic          neg1;
  logic          neg2;
  logic          neg3;
  logic [63:0]   pp [NA][NB];
  logic [PW-1:0] acc;
  logic [OW-1:0] mag;

  always_comb begin
    a_abs = a[AW-1] ? AW'(-a) : AW'(a);
    b_abs = b[BW-1] ? BW'(-b) : BW'(b);
  end

  always_comb begin
    acc = RND;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[AW-1] ^ b[BW-1];
      am   <= AP'(a_abs);
      bm   <= BP'(b_abs);
      neg2 <= neg1;
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= am[32*i +: 32] * bm[32*j +: 32];
        end
      end
      neg3 <= neg2;
      mag  <= OW'(acc >> SH);
      p    <= neg3 ? OW'(-mag) : mag;
    end
  end

endmodule

[sv/precession_theta_angle_and_rate.sv]
// ----------------------------------------------------------------------------
// precession_theta_angle_and_rate: precession angle theta and its rate
// Horner evaluation of the model cubic in elapsed centuries, fixed point.
//
//   channel  | dir | tdata (low bit up)                       | tuser
//   ---------+-----+------------------------------------------+-----------------
//   s_axis   | in  | start_epoch[37:0], end_epoch[75:38], pad | precession_model
//   m_axis   | out | angle[55:0], angle_rate[103:56]          | -
//
// One beat per cycle in, one per cycle out unless the output stalls; the pipe
// is five chained 4-stage multipliers, the input, three add and output stages.
// Reset clears the valid bits only; data registers are not reset.
// A stalled output freezes the whole pipe; s_axis_tready follows it.
// ----------------------------------------------------------------------------
module precession_theta_angle_and_rate (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // start_epoch, end_epoch, zero pad
  input  logic [2:0]   s_axis_tuser,   // precession_model
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata    // angle, angle_rate
);

  localparam int L  = ptar_pkg::MUL_LAT;
  localparam int VN = 5 * L + 5;
  localparam int DW = ptar_pkg::DATE_W;
  localparam int AGW = ptar_pkg::ANGLE_W;
  localparam int RTW = ptar_pkg::RATE_W;
  localparam logic signed [48:0] HALF_CENT = 49'sd1 <<< 39;
  localparam logic signed [63:0] K_OP = $signed({1'b0, ptar_pkg::ARCSEC_K});
  localparam logic [AGW-1:0] ANG_MAX = {1'b0, {(AGW-1){1'b1}}};
  localparam logic [AGW-1:0] ANG_MIN = {1'b1, {(AGW-1){1'b0}}};
  localparam logic [RTW-1:0] RATE_MAX = {1'b0, {(RTW-1){1'b1}}};
  localparam logic [RTW-1:0] RATE_MIN = {1'b1, {(RTW-1){1'b0}}};

  typedef struct packed {
    logic signed [48:0] u;
    logic signed [47:0] t;
    ptar_pkg::model_t   m;
  } ctx_ut_t;

  typedef struct packed {
    logic signed [47:0] t;
    ptar_pkg::model_t   m;
  } ctx_t_t;

  logic en;
  logic [VN-1:0] vld;

  // input stage
  ptar_pkg::model_t   mdl_in;
  ptar_pkg::coef_t    cf_in;
  logic [DW-1:0]      epoch_in;
  logic signed [38:0] d1_0;
  logic signed [38:0] dt_0;
  ptar_pkg::model_t   m0;
  logic signed [49:0] rc_0;

  // elapsed and start centuries
  logic signed [47:0] u_raw;
  logic signed [47:0] t_raw;
  ptar_pkg::model_t   m_d1 [L];
  ptar_pkg::coef_t    cf_1;
  logic signed [48:0] u1;
  logic signed [47:0] t1;
  ptar_pkg::model_t   m1;

  // first products
  ptar_pkg::coef_t    cf_m2;
  logic signed [29:0] p1;
  logic signed [29:0] p2;
  logic signed [35:0] p3;
  logic signed [37:0] p4;
  ctx_ut_t            c_d2 [L];
  ptar_pkg::coef_t    cf_2;
  logic signed [33:0] x2;
  logic signed [36:0] h0;
  logic signed [38:0] g0;
  logic signed [48:0] u2;
  logic signed [47:0] t2;
  ptar_pkg::model_t   m2;

  // second products
  logic signed [41:0] q;
  logic signed [43:0] h1;
  logic signed [45:0] g1;
  ctx_t_t             c_d3 [L];
  ptar_pkg::coef_t    cf_3;
  logic signed [45:0] h2;
  logic signed [46:0] g2;
  logic signed [47:0] t3;
  ptar_pkg::model_t   m3;

  // third and final products
  logic signed [53:0] h3;
  logic signed [46:0] gk;
  ptar_pkg::model_t   m_d4 [L];
  ptar_pkg::coef_t    cf_4;
  logic signed [49:0] rc_4;
  logic signed [56:0] ang;
  logic signed [48:0] rate;
  logic [AGW-1:0]     ang_sat;
  logic [RTW-1:0]     rate_sat;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[VN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[VN-2:0], s_axis_tvalid};
    end
  end

  // codes above Lieske fall back to FK5
  always_comb begin
    mdl_in   = s_axis_tuser[2] ? ptar_pkg::MODEL_FK5 : ptar_pkg::model_t'(s_axis_tuser);
    cf_in    = ptar_pkg::model_coef(mdl_in);
    epoch_in = cf_in.julian ? ptar_pkg::EPOCH_J2000 : ptar_pkg::EPOCH_B1850;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_0 <= $signed({1'b0, s_axis_tdata[DW-1:0]}) - $signed({1'b0, epoch_in});
      dt_0 <= $signed({1'b0, s_axis_tdata[2*DW-1:DW]})
            - $signed({1'b0, s_axis_tdata[DW-1:0]});
      m0   <= mdl_in;
    end
  end

  assign rc_0 = $signed({1'b0, (m0 == ptar_pkg::MODEL_FK5) ?
                                ptar_pkg::RC_JUL : ptar_pkg::RC_TROP});

  ptar_mul #(.AW(39), .BW(50), .SH(40), .OW(48)) u_mul_u (
    .clk(clk), .en(en), .a(d1_0), .b(rc_0), .p(u_raw)
  );

  ptar_mul #(.AW(39), .BW(50), .SH(40), .OW(48)) u_mul_t (
    .clk(clk), .en(en), .a(dt_0), .b(rc_0), .p(t_raw)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      m_d1[0] <= m0;
      for (int i = 1; i < L; i++) begin
        m_d1[i] <= m_d1[i-1];
      end
    end
  end

  assign cf_1 = ptar_pkg::model_coef(m_d1[L-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      u1 <= 49'(u_raw) - (cf_1.half ? HALF_CENT : 49'sd0);
      t1 <= t_raw;
      m1 <= m_d1[L-1];
    end
  end

  assign cf_m2 = ptar_pkg::model_coef(m1);

  ptar_mul #(.AW(49), .BW(22), .SH(40), .OW(30)) u_mul_p1 (
    .clk(clk), .en(en), .a(u1), .b(cf_m2.c12), .p(p1)
  );

  ptar_mul #(.AW(49), .BW(22), .SH(40), .OW(30)) u_mul_p2 (
    .clk(clk), .en(en), .a(u1), .b(cf_m2.c21), .p(p2)
  );

  ptar_mul #(.AW(29), .BW(48), .SH(40), .OW(36)) u_mul_p3 (
    .clk(clk), .en(en), .a(cf_m2.c30), .b(t1), .p(p3)
  );

  ptar_mul #(.AW(31), .BW(48), .SH(40), .OW(38)) u_mul_p4 (
    .clk(clk), .en(en), .a(cf_m2.c30x3), .b(t1), .p(p4)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      c_d2[0] <= '{u: u1, t: t1, m: m1};
      for (int i = 1; i < L; i++) begin
        c_d2[i] <= c_d2[i-1];
      end
    end
  end

  assign cf_2 = ptar_pkg::model_coef(c_d2[L-1].m);

  // a2 = c20 + p2 folds into both Horner starts
  always_ff @(posedge clk) begin
    if (en) begin
      x2 <= 34'(cf_2.c11) + 34'(p1);
      h0 <= 37'(p3) + 37'(p2) + 37'(cf_2.c20);
      g0 <= 39'(p4) + (39'(p2) <<< 1) + (39'(cf_2.c20) <<< 1);
      u2 <= c_d2[L-1].u;
      t2 <= c_d2[L-1].t;
      m2 <= c_d2[L-1].m;
    end
  end

  ptar_mul #(.AW(49), .BW(34), .SH(40), .OW(42)) u_mul_q (
    .clk(clk), .en(en), .a(u2), .b(x2), .p(q)
  );

  ptar_mul #(.AW(37), .BW(48), .SH(40), .OW(44)) u_mul_h1 (
    .clk(clk), .en(en), .a(h0), .b(t2), .p(h1)
  );

  ptar_mul #(.AW(39), .BW(48), .SH(40), .OW(46)) u_mul_g1 (
    .clk(clk), .en(en), .a(g0), .b(t2), .p(g1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      c_d3[0] <= '{t: t2, m: m2};
      for (int i = 1; i < L; i++) begin
        c_d3[i] <= c_d3[i-1];
      end
    end
  end

  assign cf_3 = ptar_pkg::model_coef(c_d3[L-1].m);

  // a1 = c10 + q
  always_ff @(posedge clk) begin
    if (en) begin
      h2 <= 46'(h1) + 46'(q) + 46'(cf_3.c10);
      g2 <= 47'(g1) + 47'(q) + 47'(cf_3.c10);
      t3 <= c_d3[L-1].t;
      m3 <= c_d3[L-1].m;
    end
  end

  ptar_mul #(.AW(46), .BW(48), .SH(40), .OW(54)) u_mul_h3 (
    .clk(clk), .en(en), .a(h2), .b(t3), .p(h3)
  );

  ptar_mul #(.AW(47), .BW(64), .SH(64), .OW(47)) u_mul_gk (
    .clk(clk), .en(en), .a(g2), .b(K_OP), .p(gk)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      m_d4[0] <= m3;
      for (int i = 1; i < L; i++) begin
        m_d4[i] <= m_d4[i-1];
      end
    end
  end

  assign cf_4 = ptar_pkg::model_coef(m_d4[L-1]);
  assign rc_4 = $signed({1'b0, cf_4.julian ? ptar_pkg::RC_JUL : ptar_pkg::RC_TROP});

  ptar_mul #(.AW(54), .BW(64), .SH(64), .OW(57)) u_mul_ang (
    .clk(clk), .en(en), .a(h3), .b(K_OP), .p(ang)
  );

  // radian per century to radian per day
  ptar_mul #(.AW(47), .BW(50), .SH(52), .OW(49)) u_mul_rate (
    .clk(clk), .en(en), .a(gk), .b(rc_4), .p(rate)
  );

  always_comb begin
    if (ang[AGW] != ang[AGW-1]) begin
      ang_sat = ang[AGW] ? ANG_MIN : ANG_MAX;
    end else begin
      ang_sat = ang[AGW-1:0];
    end
    if (rate[RTW] != rate[RTW-1]) begin
      rate_sat = rate[RTW] ? RATE_MIN : RATE_MAX;
    end else begin
      rate_sat = rate[RTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {rate_sat, ang_sat};
    end
  end

endmodule

[sv/ptar_chk.sv]
// ----------------------------------------------------------------------------
// ptar_chk: port-level checks for the precession angle block
// Ready/stall coupling, reset behavior, output hold and result range.
// ----------------------------------------------------------------------------
module ptar_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [ptar_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  // input side is held exactly while a finished beat waits
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("s_axis_tready does not track the output stall");

  a_no_beat_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed or dropped");

  // theta stays below 2^52 lsb and its rate below 2^43 lsb for any dates
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[55:52] == 4'h0 || m_axis_tdata[55:52] == 4'hF) &&
      (m_axis_tdata[103:99] == 5'h00 || m_axis_tdata[103:99] == 5'h1F))
    else $error("result outside its reachable range");

endmodule

bind precession_theta_angle_and_rate ptar_chk u_ptar_chk (
  .clk(clk),
  .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

[tb/precession_theta_angle_and_rate_chk.sv]
// ----------------------------------------------------------------------------
// precession_theta_angle_and_rate_chk: output check for the theta block
// Watches both stream channels. Each input beat is turned into a predicted
// angle/rate pair by a fixed-point model of the block. Each output beat is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module precession_theta_angle_and_rate_chk (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // start_epoch, end_epoch, zero pad
  input  logic [2:0]   s_axis_tuser,   // precession_model
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,   // angle, angle_rate
  output int           mismatches,
  output int           outstanding
);

  typedef struct packed {
    logic [55:0] angle;
    logic [47:0] rate;
  } theta_t;

  localparam longint B1850_Q16 = 64'sd2396758 * 64'sd65536 + 64'sd13342;
  localparam longint J2000_Q16 = 64'sd2451545 * 64'sd65536;
  localparam longint TROP_Q16  = 64'sd36524 * 64'sd65536 + 64'sd14410;
  localparam longint JUL_Q16   = 64'sd36525 * 64'sd65536;
  localparam longint TROP_INV  = 64'((128'd1 << 80) / 128'(TROP_Q16));
  localparam longint JUL_INV   = 64'((128'd1 << 80) / 128'(JUL_Q16));
  localparam longint ASEC_RAD  =
    64'(((128'(64'hC90FDAA22168C235) << 18) + 128'd324000) / 128'd648000);

  theta_t pending_theta[$];
  theta_t want;
  int     bad;

  // decimal n/d in 2^-32 arcsec, rounded to nearest
  function automatic longint q32(longint n, longint d);
    return (n * 64'sd8589934592 + d) / (2 * d);
  endfunction

  // (a*b) >> s, rounded half away from zero, clamped to the 64-bit range
  function automatic longint mul_round(longint a, longint b, int s);
    logic         neg;
    logic [63:0]  ua, ub, mag;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    p   = 128'(ua) * 128'(ub);
    p   = (p + (128'd1 << (s - 1))) >> s;
    mag = (p > 128'(64'h7FFF_FFFF_FFFF_FFFF)) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic longint clamp_bits(longint v, int bits);
    longint lim;
    lim = (64'sd1 <<< (bits - 1)) - 1;
    if (v > lim) begin
      v = lim;
    end
    if (v < -lim - 1) begin
      v = -lim - 1;
    end
    return v;
  endfunction

  function automatic theta_t theta_and_rate(logic [37:0] j1, logic [37:0] j2,
                                            logic [2:0] code);
    longint c10, c11, c12, c20, c21, c30;
    longint epoch, rc, d1, dt, u, t, a1, a2, h, g, ang, rate;
    logic   half, jul;
    theta_t r;
    half = 1'b0;
    jul  = 1'b0;
    case (code)
      ptar_pkg::MODEL_NEWCOMB: begin
        c10 = q32(2004682, 1000);      c11 = -q32(853, 1000);   c12 = 0;
        c20 = -q32(426, 1000);         c21 = 0;                 c30 = -q32(42, 1000);
        half = 1'b1;
      end
      ptar_pkg::MODEL_ANDOYER: begin
        c10 = q32(2005112, 1000);      c11 = -q32(8529, 10000); c12 = -q32(37, 100000);
        c20 = -q32(4265, 10000);       c21 = -q32(37, 100000);  c30 = -q32(418, 10000);
      end
      ptar_pkg::MODEL_KINOSHITA: begin
        c10 = q32(20051125, 10000);    c11 = -q32(85294, 100000);
        c12 = -q32(365, 1000000);      c20 = -q32(42647, 100000);
        c21 = -q32(365, 1000000);      c30 = -q32(41802, 1000000);
      end
      ptar_pkg::MODEL_LIESKE: begin
        c10 = q32(2004684, 1000);      c11 = -q32(8532, 10000); c12 = -q32(317, 1000000);
        c20 = -q32(4266, 10000);       c21 = -q32(32, 100000);  c30 = -q32(418, 10000);
        half = 1'b1;
      end
      default: begin
        // codes above the known models use FK5
        c10 = q32(20043109, 10000);    c11 = -q32(85330, 100000);
        c12 = -q32(217, 1000000);      c20 = -q32(42665, 100000);
        c21 = -q32(217, 1000000);      c30 = -q32(41833, 1000000);
        jul = 1'b1;
      end
    endcase
    epoch = jul ? J2000_Q16 : B1850_Q16;
    rc    = jul ? JUL_INV : TROP_INV;
    d1    = $signed({26'd0, j1}) - epoch;
    dt    = $signed({26'd0, j2}) - $signed({26'd0, j1});
    u     = mul_round(d1, rc, 40);
    t     = mul_round(dt, rc, 40);
    if (half) begin
      u = u - (64'sd1 <<< 39);
    end
    a1 = c10 + mul_round(u, c11 + mul_round(u, c12, 40), 40);
    a2 = c20 + mul_round(u, c21, 40);
    h  = mul_round(c30, t, 40) + a2;
    h  = mul_round(h, t, 40) + a1;
    h  = mul_round(h, t, 40);
    g  = mul_round(3 * c30, t, 40) + 2 * a2;
    g  = mul_round(g, t, 40) + a1;
    ang  = mul_round(h, ASEC_RAD, 64);
    rate = mul_round(mul_round(g, ASEC_RAD, 64), rc, 52);
    r.angle = 56'(clamp_bits(ang, 56));
    r.rate  = 48'(clamp_bits(rate, 48));
    return r;
  endfunction

  initial bad = 0;

  always @(posedge clk) begin
    if (!rst) begin
      // retire before predict so a same-edge beat never matches itself
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_theta.size() == 0) begin
          bad++;
          if (bad <= 10) begin
            $display("unexpected output beat: angle %h rate %h",
                     m_axis_tdata[55:0], m_axis_tdata[103:56]);
          end
        end else begin
          want = pending_theta.pop_front();
          if (m_axis_tdata[55:0] !== want.angle || m_axis_tdata[103:56] !== want.rate) begin
            bad++;
            if (bad <= 10) begin
              $display("theta mismatch: angle exp %h got %h, rate exp %h got %h",
                       want.angle, m_axis_tdata[55:0], want.rate, m_axis_tdata[103:56]);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_theta.push_back(theta_and_rate(s_axis_tdata[37:0], s_axis_tdata[75:38],
                                               s_axis_tuser));
      end
    end
    mismatches  <= bad;
    outstanding <= pending_theta.size();
  end

endmodule

[tb/precession_theta_angle_and_rate_tb.sv]
// ----------------------------------------------------------------------------
// precession_theta_angle_and_rate_tb: stream test of the theta block
// Directed date pairs (extremes, epochs, zero and negative spans, all model
// codes) followed by random pairs under changing input/output throttling,
// including a long output hold-off that backs up the pipe.
// ----------------------------------------------------------------------------
module precession_theta_angle_and_rate_tb;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_LEN    = 300;
  localparam logic [37:0] B1850_DATE = 38'(64'd2396758 * 64'd65536 + 64'd13342);
  localparam logic [37:0] J2000_DATE = 38'(64'd2451545 * 64'd65536);
  localparam logic [37:0] DATE_MAX   = '1;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;   // start_epoch, end_epoch, zero pad
  logic [2:0]   s_axis_tuser = '0;   // precession_model
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // angle, angle_rate

  int mismatches;
  int outstanding;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet     = 0;
  bit hold_req  = 1'b0;

  precession_theta_angle_and_rate dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  precession_theta_angle_and_rate_chk chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always #4 clk = ~clk;

  // output throttle; a hold request blocks the output for a fixed stretch
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req      <= 1'b0;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  function automatic logic [37:0] pick_date();
    logic [37:0] d;
    case ($urandom_range(9))
      0, 1, 2: d = 38'({$urandom, $urandom});
      3: begin
        case ($urandom_range(3))
          0: d = '0;
          1: d = DATE_MAX;
          2: d = B1850_DATE + 38'($urandom_range(2000)) - 38'd1000;
          default: d = J2000_DATE + 38'($urandom_range(2000)) - 38'd1000;
        endcase
      end
      default: d = {22'($urandom_range(2200000, 2700000)), 16'($urandom)};
    endcase
    return d;
  endfunction

  task automatic offer(logic [37:0] j1, logic [37:0] j2, logic [2:0] code);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, j2, j1};
    s_axis_tuser  <= code;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_phase(int n, int idle, int stall, bit with_hold);
    logic [37:0] j1, j2;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == 60) begin
        hold_req = 1'b1;
      end
      j1 = pick_date();
      // half the time a span within half a century either way, else unrelated dates
      if ($urandom_range(1)) begin
        j2 = j1 + 38'($signed(32'($urandom_range(32'h7FFF_FFFF))) - 32'sh4000_0000);
      end else begin
        j2 = pick_date();
      end
      offer(j1, j2, 3'($urandom_range(7)));
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every model code over a typical span
    for (int c = 0; c < 8; c++) begin
      offer(J2000_DATE, J2000_DATE + 38'(64'd36525 * 64'd65536), 3'(c));
    end
    offer('0, '0, ptar_pkg::MODEL_NEWCOMB);
    offer(DATE_MAX, DATE_MAX, ptar_pkg::MODEL_FK5);
    offer('0, DATE_MAX, ptar_pkg::MODEL_LIESKE);
    offer(DATE_MAX, '0, ptar_pkg::MODEL_KINOSHITA);     // end before start
    offer('0, DATE_MAX, 3'd7);
    offer(DATE_MAX, '0, ptar_pkg::MODEL_NEWCOMB);
    offer(B1850_DATE, B1850_DATE, ptar_pkg::MODEL_ANDOYER);  // zero span at the epoch
    offer(J2000_DATE, J2000_DATE, ptar_pkg::MODEL_FK5);
    offer(J2000_DATE, B1850_DATE, ptar_pkg::MODEL_FK5);
    offer(B1850_DATE, J2000_DATE, ptar_pkg::MODEL_LIESKE);
    offer(J2000_DATE + 38'd1, J2000_DATE, 3'd5);
    offer(38'h2A_AAAA_AAAA, 38'h15_5555_5555, 3'd6);
    drain();

    random_phase(340, 0, 0, 1'b1);
    random_phase(330, 65, 0, 1'b0);
    random_phase(330, 0, 65, 1'b0);
    random_phase(330, 22, 22, 1'b0);

    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
